// ===== rtl/dnt_pkg.sv =====
package dnt_pkg;

  localparam int unsigned KEY_W    = 64;
  localparam int unsigned SECTOR_W = 16;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned SLOT_SPAN = 64;  // slots reachable through the slot field

  typedef enum logic [1:0] {
    ACT_FIND   = 2'd0,
    ACT_ADD    = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_READ   = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_DUP       = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  // Query held steady for the whole scan
  typedef struct packed {
    action_e             action;
    logic [KEY_W-1:0]    key;
    logic [SECTOR_W-1:0] sector;
    logic                is_dir;
    logic [SLOT_W-1:0]   idx;
  } query_t;

  // Token that walks the cell row, one cell per cycle
  typedef struct packed {
    logic                vld;
    logic                found;
    logic [SLOT_W-1:0]   slot;
    logic [SECTOR_W-1:0] sector;
    logic                is_dir;
    logic                free_ok;
    logic [SLOT_W-1:0]   free_slot;
  } token_t;

  // Broadcast write into the lowest free cell
  typedef struct packed {
    logic                en;
    logic [KEY_W-1:0]    key;
    logic [SECTOR_W-1:0] sector;
    logic                is_dir;
  } wb_t;

  typedef struct packed {
    status_e             status;
    logic [SLOT_W-1:0]   slot;
    logic [SECTOR_W-1:0] sector;
    logic                is_dir;
  } result_t;

endpackage

// ===== rtl/dnt_req_if.sv =====
interface dnt_req_if
  import dnt_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [1:0]          action;
  logic [KEY_W-1:0]    name_key;
  logic [SECTOR_W-1:0] new_sector;
  logic                mark_dir;
  logic [SLOT_W-1:0]   slot_index;

  modport source (
    output valid, action, name_key, new_sector, mark_dir, slot_index,
    input  ready
  );
  modport sink (
    input  valid, action, name_key, new_sector, mark_dir, slot_index,
    output ready
  );
endinterface

// ===== rtl/dnt_rsp_if.sv =====
interface dnt_rsp_if
  import dnt_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [SLOT_W-1:0]   slot;
  logic [SECTOR_W-1:0] sector;
  logic                is_dir;

  modport source (
    output valid, status, slot, sector, is_dir,
    input  ready
  );
  modport sink (
    input  valid, status, slot, sector, is_dir,
    output ready
  );
endinterface

// ===== rtl/dnt_cell.sv =====
module dnt_cell
  import dnt_pkg::*;
#(
  parameter int CELL_IDX = 0
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  query_t query_i,
  input  wb_t    wb_i,
  input  token_t tok_i,
  output token_t tok_o
);

  localparam logic [SLOT_W-1:0] SLOT_LO  = SLOT_W'(CELL_IDX);
  localparam logic              READABLE = (CELL_IDX < SLOT_SPAN);

  logic                used_q, used_d;
  logic                dir_q, dir_d;
  logic [SECTOR_W-1:0] sector_q;
  logic [KEY_W-1:0]    name_q;
  logic                cand_q, cand_d;
  token_t              tok_q, tok_d;
  logic                hit;
  logic                take;

  assign hit  = used_q && (name_q == query_i.key);
  assign take = wb_i.en && cand_q;

  // Examine the passing token against this entry
  always_comb begin
    tok_d  = tok_i;
    used_d = used_q;
    dir_d  = dir_q;
    cand_d = cand_q;
    if (tok_i.vld) begin
      case (query_i.action) inside
        ACT_FIND, ACT_ADD: begin
          if (!tok_i.found && hit) begin
            tok_d.found  = 1'b1;
            tok_d.slot   = SLOT_LO;
            tok_d.sector = sector_q;
            tok_d.is_dir = dir_q;
          end
        end
        ACT_REMOVE: begin
          if (!tok_i.found && hit) begin
            tok_d.found  = 1'b1;
            tok_d.slot   = SLOT_LO;
            tok_d.sector = sector_q;
            tok_d.is_dir = dir_q;
            used_d       = 1'b0;
            dir_d        = 1'b0;
          end
        end
        default: begin
          if (READABLE && (query_i.idx == SLOT_LO)) begin
            tok_d.found  = 1'b1;
            tok_d.slot   = SLOT_LO;
            tok_d.sector = sector_q;
            tok_d.is_dir = dir_q;
          end
        end
      endcase
      // Claim the lowest free entry for a possible write-back
      cand_d = !used_q && !tok_i.free_ok;
      if (!used_q && !tok_i.free_ok) begin
        tok_d.free_ok   = 1'b1;
        tok_d.free_slot = SLOT_LO;
      end
    end
    if (take) begin
      used_d = 1'b1;
      dir_d  = wb_i.is_dir;
      cand_d = 1'b0;
    end
  end

  // Entry flags, sector and token stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= 1'b0;
      dir_q    <= 1'b0;
      sector_q <= '0;
      cand_q   <= 1'b0;
      tok_q    <= '0;
    end else begin
      used_q <= used_d;
      dir_q  <= dir_d;
      cand_q <= cand_d;
      tok_q  <= tok_d;
      if (take) begin
        sector_q <= wb_i.sector;
      end
    end
  end

  // Name is only looked at while the entry is in use
  always_ff @(posedge clk_i) begin
    if (take) begin
      name_q <= wb_i.key;
    end
  end

  assign tok_o = tok_q;

  a_cand_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cand_q |-> !used_q)
    else $error("claimed entry is already in use");

  a_take_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> used_q && !cand_q)
    else $error("write-back did not fill the entry");

  a_found_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_i.vld && tok_i.found) |=> (tok_o.found && tok_o.slot == $past(tok_i.slot)))
    else $error("earlier match overridden in a later cell");

endmodule

// ===== rtl/directory_name_table.sv =====
// Directory name table: a fixed table of TABLE_ENTRIES slots, each holding a
// name key, a header sector, an in-use bit and a directory bit.
// Channels: req_i carries one operation (find, add, remove, read by index);
// rsp_o returns exactly one result per operation, in order. Both channels
// transfer when valid and ready are high at a rising clock edge.
// Operation: a query token walks a row of one cell per slot, one cell per
// cycle, so every operation scans the whole row; an add then writes the
// lowest free slot in the cycle after the scan ends.
// Path: the request goes to the query register, the token through the token
// register of each cell, and the result through a holding register into the
// output register. One operation is in flight at a time: req_i.ready is
// high only while no operation is in the row.
// Stall: the result waits in an output register while rsp_o.ready is low;
// a finished scan waits in a holding register until that register frees,
// and no new request is taken meanwhile.
// Reset: all slots free, sectors and directory bits zero; no result pending.
module directory_name_table
  import dnt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 64,
  parameter int NAME_BYTES    = 8
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  dnt_req_if.sink   req_i,
  dnt_rsp_if.source rsp_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [1:0]       state_q, state_d;
  logic             launch_q;
  query_t           query_q;
  logic [KEY_W-1:0] key_c;
  result_t          pend_q, pend_d;
  result_t          out_q;
  logic             out_vld_q;
  token_t           chain [TABLE_ENTRIES+1];
  token_t           tail;
  wb_t              wb;
  logic             req_xfer;
  logic             out_load;

  assign req_xfer    = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == S_IDLE);

  // Cut the key to NAME_BYTES bytes and zero everything after the first zero byte
  always_comb begin
    logic alive;
    alive = 1'b1;
    key_c = '0;
    for (int b = 0; b < 8; b++) begin
      if (b >= NAME_BYTES || req_i.name_key[8*b +: 8] == 8'd0) begin
        alive = 1'b0;
      end
      if (alive) begin
        key_c[8*b +: 8] = req_i.name_key[8*b +: 8];
      end
    end
  end

  // Capture the query and launch the token
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      launch_q <= 1'b0;
    end else begin
      launch_q <= req_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      query_q.action <= action_e'(req_i.action);
      query_q.key    <= key_c;
      query_q.sector <= req_i.new_sector;
      query_q.is_dir <= req_i.mark_dir;
      query_q.idx    <= req_i.slot_index;
    end
  end

  // Row of cells
  always_comb begin
    chain[0]     = '0;
    chain[0].vld = launch_q;
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    dnt_cell #(
      .CELL_IDX(i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .query_i(query_q),
      .wb_i   (wb),
      .tok_i  (chain[i]),
      .tok_o  (chain[i+1])
    );
  end

  assign tail = chain[TABLE_ENTRIES];

  // Resolve the finished scan into a result and an optional write-back
  always_comb begin
    pend_d    = '0;
    wb.en     = 1'b0;
    wb.key    = query_q.key;
    wb.sector = query_q.sector;
    wb.is_dir = query_q.is_dir;
    case (query_q.action) inside
      ACT_FIND, ACT_REMOVE: begin
        if (tail.found) begin
          pend_d = '{ST_OK, tail.slot, tail.sector, tail.is_dir};
        end else begin
          pend_d.status = ST_NOT_FOUND;
        end
      end
      ACT_ADD: begin
        if (tail.found) begin
          pend_d = '{ST_DUP, tail.slot, tail.sector, tail.is_dir};
        end else if (tail.free_ok) begin
          pend_d = '{ST_OK, tail.free_slot, query_q.sector, query_q.is_dir};
          wb.en  = tail.vld;
        end else begin
          pend_d.status = ST_FULL;
        end
      end
      default: begin
        if (int'(query_q.idx) >= TABLE_ENTRIES) begin
          pend_d.status = ST_NOT_FOUND;
          pend_d.slot   = query_q.idx;
        end else begin
          pend_d = '{ST_OK, query_q.idx, tail.sector, tail.is_dir};
        end
      end
    endcase
  end

  assign out_load = (state_q == S_LOAD) && (!out_vld_q || rsp_o.ready);

  // Sequence one operation at a time
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (req_xfer) state_d = S_SCAN;
      S_SCAN: if (tail.vld) state_d = S_LOAD;
      S_LOAD: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Hold the scan result, then the output register
  always_ff @(posedge clk_i) begin
    if (state_q == S_SCAN && tail.vld) begin
      pend_q <= pend_d;
    end
    if (out_load) begin
      out_q <= pend_q;
    end
  end

  assign rsp_o.valid  = out_vld_q;
  assign rsp_o.status = out_q.status;
  assign rsp_o.slot   = out_q.slot;
  assign rsp_o.sector = out_q.sector;
  assign rsp_o.is_dir = out_q.is_dir;

  a_tail_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.vld |-> state_q == S_SCAN)
    else $error("token left the row outside a scan");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> (!launch_q && !tail.vld))
    else $error("token in flight while idle");

  a_wb_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wb.en |=> (pend_q.status == ST_OK && state_q == S_LOAD))
    else $error("write-back without a successful add");

endmodule

// ===== tb/directory_name_table_test.sv =====
`timescale 1ns / 100ps

module directory_name_table_test;
  import dnt_pkg::*;

  localparam int SLOTS      = 64;
  localparam int NAME_LEN   = 8;
  localparam int RANDOM_OPS = 1450;
  localparam int SCRIPT_LEN = 25;
  localparam int SHOW_MAX   = 10;
  localparam int POOL_SIZE  = 16;

  typedef struct packed {
    action_e             act;
    logic [KEY_W-1:0]    key;
    logic [SECTOR_W-1:0] sector;
    logic                dir;
    logic [SLOT_W-1:0]   idx;
  } dir_op_t;

  // One scripted operation; want is used only where typed is set
  typedef struct packed {
    dir_op_t op;
    logic    typed;
    result_t want;
  } script_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  dnt_req_if req_bus ();
  dnt_rsp_if rsp_bus ();

  directory_name_table #(
    .TABLE_ENTRIES (SLOTS),
    .NAME_BYTES    (NAME_LEN)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_bus),
    .rsp_o  (rsp_bus)
  );

  // Predicted contents of the directory
  logic [KEY_W-1:0]    shelf_name   [SLOTS] = '{default: '0};
  logic [SECTOR_W-1:0] shelf_sector [SLOTS] = '{default: '0};
  logic                shelf_used   [SLOTS] = '{default: '0};
  logic                shelf_dir    [SLOTS] = '{default: '0};

  result_t          outcomes_due [$];
  logic [KEY_W-1:0] name_pool [POOL_SIZE];
  bit               calm = 1'b0;
  int               faults = 0;
  int               scripted_ops = 0;
  int               random_ops = 0;
  int               table_fills = 0;
  int               seen_status [4] = '{default: 0};

  // Extremes, each operation, name termination, duplicates and removal
  script_row_t script [SCRIPT_LEN] = '{
    '{'{ACT_READ,   64'h0,                   16'h0,    1'b0, 6'd0},  1'b1,
      '{ST_OK,        6'd0,  16'h0,    1'b0}},
    '{'{ACT_READ,   64'h0,                   16'h0,    1'b0, 6'd63}, 1'b1,
      '{ST_OK,        6'd63, 16'h0,    1'b0}},
    '{'{ACT_FIND,   64'h0,                   16'h0,    1'b0, 6'd0},  1'b1,
      '{ST_NOT_FOUND, 6'd0,  16'h0,    1'b0}},
    '{'{ACT_REMOVE, 64'h0000_0000_0063_6261, 16'h0,    1'b0, 6'd0},  1'b1,
      '{ST_NOT_FOUND, 6'd0,  16'h0,    1'b0}},
    '{'{ACT_ADD,    64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b1, 6'd0},  1'b1,
      '{ST_OK,        6'd0,  16'hFFFF, 1'b1}},
    '{'{ACT_ADD,    64'hFFFF_FFFF_FFFF_FFFF, 16'h0,    1'b0, 6'd0},  1'b1,
      '{ST_DUP,       6'd0,  16'hFFFF, 1'b1}},
    '{'{ACT_ADD,    64'h0,                   16'h0,    1'b0, 6'd0},  1'b1,
      '{ST_OK,        6'd1,  16'h0,    1'b0}},
    '{'{ACT_FIND,   64'hFFFF_FFFF_FFFF_FF00, 16'h0,    1'b0, 6'd0},  1'b1,
      '{ST_OK,        6'd1,  16'h0,    1'b0}},
    '{'{ACT_ADD,    64'h0000_0000_0072_6964, 16'h1234, 1'b1, 6'd63}, 1'b0, '0},
    '{'{ACT_ADD,    64'hDEAD_BEEF_0000_6261, 16'h0BAD, 1'b0, 6'd0},  1'b0, '0},
    '{'{ACT_FIND,   64'h0000_0000_0000_6261, 16'h0,    1'b0, 6'd0},  1'b0, '0},
    '{'{ACT_ADD,    64'h1234_5678_9A00_6261, 16'h7777, 1'b1, 6'd0},  1'b0, '0},
    '{'{ACT_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0,    1'b0, 6'd0},  1'b1,
      '{ST_OK,        6'd0,  16'hFFFF, 1'b1}},
    '{'{ACT_READ,   64'h0,                   16'h0,    1'b0, 6'd0},  1'b1,
      '{ST_OK,        6'd0,  16'hFFFF, 1'b0}},
    '{'{ACT_FIND,   64'hFFFF_FFFF_FFFF_FFFF, 16'h0,    1'b0, 6'd0},  1'b1,
      '{ST_NOT_FOUND, 6'd0,  16'h0,    1'b0}},
    '{'{ACT_ADD,    64'h0000_0000_0000_0078, 16'h0005, 1'b1, 6'd0},  1'b0, '0},
    '{'{ACT_REMOVE, 64'h0000_0000_0000_0078, 16'h0,    1'b0, 6'd0},  1'b0, '0},
    '{'{ACT_REMOVE, 64'h0000_0000_0000_0078, 16'h0,    1'b0, 6'd0},  1'b1,
      '{ST_NOT_FOUND, 6'd0,  16'h0,    1'b0}},
    '{'{ACT_READ,   64'h0,                   16'h0,    1'b0, 6'd2},  1'b0, '0},
    '{'{ACT_FIND,   64'h0000_0000_0000_0001, 16'h0,    1'b0, 6'd0},  1'b1,
      '{ST_NOT_FOUND, 6'd0,  16'h0,    1'b0}},
    '{'{ACT_ADD,    64'h5555_5555_5555_5555, 16'hAAAA, 1'b0, 6'd63}, 1'b0, '0},
    '{'{ACT_READ,   64'h0,                   16'h0,    1'b0, 6'd42}, 1'b0, '0},
    '{'{ACT_FIND,   64'hAAAA_AAAA_AAAA_AAAA, 16'h0,    1'b0, 6'd0},  1'b1,
      '{ST_NOT_FOUND, 6'd0,  16'h0,    1'b0}},
    '{'{ACT_REMOVE, 64'h0,                   16'h0,    1'b0, 6'd0},  1'b1,
      '{ST_OK,        6'd1,  16'h0,    1'b0}},
    '{'{ACT_FIND,   64'hFF00_0000_0072_6964, 16'h0,    1'b0, 6'd0},  1'b0, '0}
  };

  always #5 clk_i = ~clk_i;

  // Keep the name bytes up to the first zero byte, clear the rest
  function automatic logic [KEY_W-1:0] canonical_name(logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] name;
    bit               ended;
    name  = '0;
    ended = 1'b0;
    for (int b = 0; b < NAME_LEN; b++) begin
      if (key[8*b +: 8] == 8'h00) ended = 1'b1;
      if (!ended) name[8*b +: 8] = key[8*b +: 8];
    end
    return name;
  endfunction

  // Scramble the bytes past the terminator; they must not affect a match
  function automatic logic [KEY_W-1:0] with_junk(logic [KEY_W-1:0] name);
    logic [KEY_W-1:0] key;
    bit               ended;
    bit               junk_on;
    key     = name;
    ended   = 1'b0;
    junk_on = ($urandom_range(0, 1) != 0);
    for (int b = 0; b < 8; b++) begin
      if (ended) begin
        if (junk_on) key[8*b +: 8] = 8'($urandom_range(0, 255));
      end else if (key[8*b +: 8] == 8'h00) begin
        ended = 1'b1;
      end
    end
    return key;
  endfunction

  function automatic logic [KEY_W-1:0] spell_name(int unsigned len);
    logic [KEY_W-1:0] key;
    key = '0;
    for (int b = 0; b < int'(len); b++) key[8*b +: 8] = 8'($urandom_range(1, 255));
    return with_junk(key);
  endfunction

  function automatic int occupancy();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) n += int'(shelf_used[i]);
    return n;
  endfunction

  // Name of some slot in use, or a fresh name on an empty table
  function automatic logic [KEY_W-1:0] stored_name();
    int start;
    start = $urandom_range(0, SLOTS - 1);
    for (int n = 0; n < SLOTS; n++)
      if (shelf_used[(start + n) % SLOTS]) return with_junk(shelf_name[(start + n) % SLOTS]);
    return spell_name($urandom_range(0, NAME_LEN));
  endfunction

  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return with_junk(name_pool[$urandom_range(0, POOL_SIZE - 1)]);
    if (r < 80) return stored_name();
    if (r < 90) return {$urandom, $urandom};
    return spell_name($urandom_range(0, NAME_LEN));
  endfunction

  function automatic dir_op_t random_op();
    dir_op_t     op;
    int unsigned r;
    r         = $urandom_range(0, 99);
    op.act    = (r < 30) ? ACT_FIND : (r < 60) ? ACT_ADD : (r < 80) ? ACT_REMOVE : ACT_READ;
    op.key    = pick_key();
    op.sector = SECTOR_W'($urandom);
    op.dir    = ($urandom_range(0, 1) != 0);
    op.idx    = SLOT_W'($urandom_range(0, SLOTS - 1));
    return op;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic result_t stored_outcome(status_e st, int s);
    result_t r;
    r.status = st;
    r.slot   = SLOT_W'(s);
    r.sector = shelf_sector[s];
    r.is_dir = shelf_dir[s];
    return r;
  endfunction

  // Apply one operation to the predicted directory and return its reply
  function automatic result_t dir_op_outcome(dir_op_t op);
    result_t          r;
    logic [KEY_W-1:0] name;
    int               hit;
    int               vacant;
    r        = '0;
    r.status = ST_NOT_FOUND;
    name     = canonical_name(op.key);
    hit      = -1;
    vacant   = -1;
    // scan downward so the lowest matching and lowest free slots win
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (shelf_used[i] && shelf_name[i] == name) hit = i;
      if (!shelf_used[i]) vacant = i;
    end
    case (op.act)
      ACT_FIND: begin
        if (hit >= 0) r = stored_outcome(ST_OK, hit);
      end
      ACT_ADD: begin
        if (hit >= 0) begin
          r = stored_outcome(ST_DUP, hit);
        end else if (vacant < 0) begin
          r.status = ST_FULL;
        end else begin
          shelf_used[vacant]   = 1'b1;
          shelf_name[vacant]   = name;
          shelf_sector[vacant] = op.sector;
          shelf_dir[vacant]    = op.dir;
          r = stored_outcome(ST_OK, vacant);
        end
      end
      ACT_REMOVE: begin
        // report the slot as it stood, then free it; the sector stays
        if (hit >= 0) begin
          r = stored_outcome(ST_OK, hit);
          shelf_used[hit] = 1'b0;
          shelf_dir[hit]  = 1'b0;
        end
      end
      default: r = stored_outcome(ST_OK, int'(op.idx));
    endcase
    return r;
  endfunction

  // Present one operation after a random gap and hold it until the transfer
  task automatic transfer_op(dir_op_t op);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_bus.valid      <= 1'b1;
    req_bus.action     <= op.act;
    req_bus.name_key   <= op.key;
    req_bus.new_sector <= op.sector;
    req_bus.mark_dir   <= op.dir;
    req_bus.slot_index <= op.idx;
    @(posedge clk_i);
    while (!req_bus.ready) @(posedge clk_i);
  endtask

  task automatic submit(dir_op_t op);
    transfer_op(op);
    outcomes_due.push_back(dir_op_outcome(op));
    random_ops++;
  endtask

  // Add fresh names until every slot is taken, then push past the end
  task automatic fill_table();
    dir_op_t op;
    int      guard;
    guard = 0;
    while (occupancy() < SLOTS && guard < 4 * SLOTS) begin
      op = random_op();
      if ($urandom_range(0, 9) != 0) begin
        op.act = ACT_ADD;
        op.key = spell_name($urandom_range(1, NAME_LEN));
      end
      submit(op);
      guard++;
    end
    repeat ($urandom_range(2, 5)) begin
      op     = random_op();
      op.act = ACT_ADD;
      submit(op);
    end
    table_fills++;
  endtask

  // Remove stored names until only a few slots stay in use
  task automatic drain_table();
    dir_op_t op;
    int      guard;
    guard = 0;
    while (occupancy() > 4 && guard < 4 * SLOTS) begin
      op = random_op();
      if ($urandom_range(0, 99) < 85) begin
        op.act = ACT_REMOVE;
        op.key = stored_name();
      end
      submit(op);
      guard++;
    end
  endtask

  task automatic check_reply();
    result_t want;
    if (outcomes_due.size() == 0) begin
      faults++;
      if (faults <= SHOW_MAX)
        $display("%0t: reply with nothing outstanding: status %0d slot %0d sector %h dir %0d",
                 $time, rsp_bus.status, rsp_bus.slot, rsp_bus.sector, rsp_bus.is_dir);
      return;
    end
    want = outcomes_due.pop_front();
    seen_status[int'(want.status)]++;
    if (rsp_bus.status !== want.status || rsp_bus.slot !== want.slot ||
        rsp_bus.sector !== want.sector || rsp_bus.is_dir !== want.is_dir) begin
      faults++;
      if (faults <= SHOW_MAX) begin
        $write("%0t: reply mismatch: expected status %0d slot %0d sector %h dir %0d,",
               $time, want.status, want.slot, want.sector, want.is_dir);
        $display(" got status %0d slot %0d sector %h dir %0d",
                 rsp_bus.status, rsp_bus.slot, rsp_bus.sector, rsp_bus.is_dir);
      end
    end
  endtask

  // Reply side: check each transfer, stall at random
  initial begin
    logic        level;
    int unsigned left;
    int unsigned r;
    level = 1'b0;
    left  = 0;
    rsp_bus.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (rsp_bus.valid && rsp_bus.ready) check_reply();
      if (left == 0) begin
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
          level = 1'b1;
          left  = $urandom_range(1, 20);
        end else if (r < 90) begin
          level = 1'b0;
          left  = $urandom_range(1, 4);
        end else begin
          level = 1'b0;
          left  = $urandom_range(10, 90);
        end
      end
      left--;
      rsp_bus.ready <= level;
    end
  end

  // Request side: scripted rows, then random batches
  initial begin
    result_t     predicted;
    int unsigned len;
    int          pick;
    req_bus.valid      <= 1'b0;
    req_bus.action     <= ACT_FIND;
    req_bus.name_key   <= '0;
    req_bus.new_sector <= '0;
    req_bus.mark_dir   <= 1'b0;
    req_bus.slot_index <= '0;

    // pair each pool name with a prefix of itself one byte shorter
    len = 1;
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i % 2 == 0) begin
        len          = $urandom_range(1, NAME_LEN);
        name_pool[i] = spell_name(len);
      end else begin
        name_pool[i] = with_junk(canonical_name(name_pool[i-1]) &
                                 ~(64'hFF << (8 * (len - 1))));
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (script[n]) begin
      transfer_op(script[n].op);
      predicted = dir_op_outcome(script[n].op);
      outcomes_due.push_back(script[n].typed ? script[n].want : predicted);
      scripted_ops++;
    end

    while (random_ops < RANDOM_OPS) begin
      calm = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 99);
      if (occupancy() == SLOTS && pick < 70) drain_table();
      else if (occupancy() < SLOTS && pick < 12) fill_table();
      else repeat ($urandom_range(15, 50)) submit(random_op());
    end
    calm = 1'b0;
    req_bus.valid <= 1'b0;

    // Drain outstanding replies, then watch for strays
    while (outcomes_due.size() != 0) @(posedge clk_i);
    repeat (SLOTS + 8) @(posedge clk_i);

    $display("Covered %0d scripted and %0d random operations, %0d passes filling all %0d slots.",
             scripted_ops, random_ops, table_fills, SLOTS);
    $display("Replies: %0d ok, %0d not found, %0d duplicate, %0d full; %0d mismatches.",
             seen_status[ST_OK], seen_status[ST_NOT_FOUND], seen_status[ST_DUP],
             seen_status[ST_FULL], faults);
    if (faults == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #(20_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
